// ----- rtl/mpdd_pkg.sv -----
`timescale 1ns / 1ps

package mpdd_pkg;

  localparam int NUM_PINS = 16;
  localparam int PIN_W    = 4;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 16;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

  // request op codes
  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              arm;
    logic              init;
    logic              check;
    logic              value;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] deadline;
  } ctrl_t;

  // per cell status back to the controller
  typedef struct packed {
    logic hit;
    logic emit;
    logic level;
  } cell_st_t;

endpackage

// ----- rtl/mpdd_cell.sv -----
`timescale 1ns / 1ps

module mpdd_cell import mpdd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ctrl_t    ctrl_i,
  input  logic     sel_i,
  input  logic     level_i,
  input  logic     token_i,
  output logic     token_o,
  output cell_st_t stat_o
);

  logic              stable_q, stable_d;
  logic              active_q, active_d;
  logic              hit_q, hit_d;
  logic              token_q;
  logic              pval_q, pval_d;
  logic [TIME_W-1:0] deadline_q, deadline_d;
  logic [TIME_W-1:0] diff;
  logic              reached;
  logic              emit;

  assign diff    = ctrl_i.now - deadline_q;
  assign reached = ~diff[TIME_W-1];
  assign emit    = token_q & hit_q;

  always_comb begin
    stable_d   = stable_q;
    active_d   = active_q;
    hit_d      = hit_q;
    pval_d     = pval_q;
    deadline_d = deadline_q;
    if (ctrl_i.arm && sel_i) begin
      active_d   = 1'b1;
      pval_d     = ctrl_i.value;
      deadline_d = ctrl_i.deadline;
    end
    if (ctrl_i.init && sel_i) begin
      stable_d = ctrl_i.value;
    end
    if (ctrl_i.check) begin
      hit_d = 1'b0;
      if (active_q && reached) begin
        active_d = 1'b0;
        hit_d    = (level_i == pval_q) && (stable_q != level_i);
      end
    end
    // confirmed change leaves when the scan token passes
    if (emit) begin
      stable_d = pval_q;
      hit_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      active_q <= 1'b0;
      hit_q    <= 1'b0;
      token_q  <= 1'b0;
    end else begin
      stable_q <= stable_d;
      active_q <= active_d;
      hit_q    <= hit_d;
      token_q  <= token_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pval_q     <= pval_d;
    deadline_q <= deadline_d;
  end

  assign token_o = token_q;
  assign stat_o  = '{hit: hit_q, emit: emit, level: pval_q};

endmodule

// ----- rtl/multi_pin_deferred_debouncer_top.sv -----
`timescale 1ns / 1ps

// deferred confirmation debouncer for a row of input pins
// request channel: start / busy; a request is taken when start is high and
//   busy is low; op selects edge (arm a pin), check (scan deadlines) or init
// edge request: no result; the pin's entry is armed with a
//   deadline of now_ms plus debounce_ms
// init request: with notify set the pin and level show on the
//   result ports in the next cycle with last set
// check request: a scan token walks the cell chain one pin per cycle; busy
//   stays high while the token is in the chain, so the next request waits for
//   the scan to finish; results leave in pin order, at most one per cycle,
//   through the output register, the final one with last set
// results: strobe_o marks one cycle per result; the receiver cannot stall,
//   so nothing is buffered beyond the output register
// config: cfg_valid_i / cfg_ready_o writes debounce_ms; ready is always high,
//   write only while idle
// reset: stable levels all ones, no pin armed, debounce_ms 20, no result
module multi_pin_deferred_debouncer_top import mpdd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op_i,
  input  logic signed [4:0] pin_i,
  input  logic              value_i,
  input  logic              notify_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [15:0]       current_levels_i,
  // result channel
  output logic              strobe_o,
  output logic [PIN_W-1:0]  changed_pin_o,
  output logic              level_o,
  output logic              last_o,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DEB_W-1:0]  cfg_data_i
);

  logic [DEB_W-1:0]    debounce_q;
  logic                accept;
  logic                pin_ok;
  logic [NUM_PINS-1:0] sel;
  ctrl_t               ctrl;
  logic [NUM_PINS-1:0] token_in, token_out;
  cell_st_t            stat [NUM_PINS];
  logic [NUM_PINS-1:0] hit_vec, emit_vec;
  logic                emit_any;
  logic [PIN_W-1:0]    emit_pin;
  logic                emit_level;
  logic                emit_last;

  logic                strobe_q, strobe_d;
  logic [PIN_W-1:0]    pin_q, pin_d;
  logic                level_q, level_d;
  logic                last_q, last_d;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // negative pins are ignored
  assign pin_ok = !pin_i[4] && ({1'b0, pin_i[3:0]} < 5'(NUM_PINS));

  always_comb begin
    sel = '0;
    if (pin_ok) begin
      sel[pin_i[3:0]] = 1'b1;
    end
  end

  assign ctrl.arm      = accept && (op_i == OP_EDGE) && pin_ok;
  assign ctrl.init     = accept && (op_i == OP_INIT) && pin_ok;
  assign ctrl.check    = accept && (op_i == OP_CHECK);
  assign ctrl.value    = value_i;
  assign ctrl.now      = now_ms_i;
  assign ctrl.deadline = now_ms_i + {{(TIME_W-DEB_W){1'b0}}, debounce_q};

  // scan token enters at pin 0 when a check is taken
  assign token_in[0] = ctrl.check;
  for (genvar g = 1; g < NUM_PINS; g++) begin : g_chain
    assign token_in[g] = token_out[g-1];
  end

  for (genvar g = 0; g < NUM_PINS; g++) begin : g_cell
    mpdd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sel_i   (sel[g]),
      .level_i (current_levels_i[g]),
      .token_i (token_in[g]),
      .token_o (token_out[g]),
      .stat_o  (stat[g])
    );
    assign hit_vec[g]  = stat[g].hit;
    assign emit_vec[g] = stat[g].emit;
  end

  assign busy = |token_out;

  // at most one cell holds the token, so at most one emits
  always_comb begin
    emit_pin   = '0;
    emit_level = 1'b0;
    for (int i = 0; i < NUM_PINS; i++) begin
      if (emit_vec[i]) begin
        emit_pin   = PIN_W'(i);
        emit_level = stat[i].level;
      end
    end
  end

  assign emit_any = |emit_vec;
  // final result when no confirmed change waits further up the chain
  assign emit_last = ((hit_vec & ~token_out) == '0);

  always_comb begin
    strobe_d = 1'b0;
    pin_d    = pin_q;
    level_d  = level_q;
    last_d   = last_q;
    if (emit_any) begin
      strobe_d = 1'b1;
      pin_d    = emit_pin;
      level_d  = emit_level;
      last_d   = emit_last;
    end else if (ctrl.init && notify_i) begin
      strobe_d = 1'b1;
      pin_d    = pin_i[3:0];
      level_d  = value_i;
      last_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      strobe_q   <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        debounce_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pin_q   <= pin_d;
    level_q <= level_d;
    last_q  <= last_d;
  end

  assign strobe_o      = strobe_q;
  assign changed_pin_o = pin_q;
  assign level_o       = level_q;
  assign last_o        = last_q;

  // scan token is never duplicated
  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(token_out))
    else $error("scan token duplicated");

  // a result that is not final means the scan is still running
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy)
    else $error("non-final result with no scan in flight");

  // a taken check starts the scan in the next cycle
  a_check_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_CHECK)) |=> busy)
    else $error("check request did not start scan");

  // hits only appear at the start of a scan
  a_hit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl.check && (hit_vec == '0)) |=> (hit_vec == '0))
    else $error("hit set outside a check");

endmodule
